[hw/rtl/code128b_check_framer_core_macros.svh]
// Assertion macros shared by the code128b check framer RTL.
// Standalone header; the files that assert include it.
`ifndef CODE128B_CHECK_FRAMER_CORE_MACROS_SVH
`define CODE128B_CHECK_FRAMER_CORE_MACROS_SVH

`ifndef SYNTH
// prop must hold at every clock edge outside reset
`define C128B_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// cond must never be true outside reset
`define C128B_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define C128B_ASSERT(lbl, clk, rst_n, prop, msg)
`define C128B_NEVER(lbl, clk, rst_n, cond, msg)
`endif

`endif

[hw/rtl/c128b_pkg.sv]
// Shared constants and the burst record type for the code128b check framer.
// No dependencies.
package c128b_pkg;

    localparam logic [7:0] START_SYMBOL = 8'd209;
    localparam logic [7:0] STOP_SYMBOL  = 8'd211;
    localparam logic [6:0] START_CODE   = 7'd104;
    localparam logic [6:0] START_WEIGHT = 7'd1;
    localparam logic [6:0] CHECK_MOD    = 7'd103;
    localparam logic [6:0] FONT_SPLIT   = 7'd95;
    localparam logic [7:0] LOW_OFFSET   = 8'd32;
    localparam logic [7:0] HIGH_OFFSET  = 8'd105;

    // One accepted character and everything needed to emit its symbols.
    typedef struct packed {
        logic       has_start;  // first character of a message
        logic [6:0] char_in;
        logic       is_last;
        logic [7:0] check_sym;  // valid when is_last
    } t_rec;

endpackage

[hw/rtl/c128b_check_unit.sv]
// Check value accumulator and burst record register.
// Depends on c128b_pkg and the assertion macro header.
`include "code128b_check_framer_core_macros.svh"

module c128b_check_unit (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [6:0]        i_char_in,
    input  logic              i_is_last,
    output logic              o_rec_valid,
    output c128b_pkg::t_rec   o_rec,
    input  logic              i_rec_pop
);

    localparam int unsigned FOLD = 128 % 103;  // 2^7 mod 103
    localparam logic [6:0] WEIGHT_WRAP = c128b_pkg::CHECK_MOD - 7'd1;

    logic            r_rec_valid;
    c128b_pkg::t_rec r_rec;
    logic [6:0]      r_sum;
    logic [6:0]      r_weight;
    logic            r_in_msg;

    logic            acc;
    logic [6:0]      code_val;
    logic [13:0]     prod;
    logic [11:0]     fold1;
    logic [9:0]      fold2;
    logic [9:0]      with_sum;
    logic [7:0]      fold3;
    logic [6:0]      n_sum;
    logic [6:0]      n_weight;
    logic [7:0]      n_check_sym;

    assign o_ready = !r_rec_valid || i_rec_pop;
    assign acc     = i_valid && o_ready;

    // code value, characters below 32 wrap modulo 103
    assign code_val = (i_char_in >= 7'd32) ? (i_char_in - 7'd32) : (i_char_in + 7'd71);

    // weighted term, then fold by 128 == 25 (mod 103) until small
    always_comb begin
        prod     = 14'(code_val) * 14'(r_weight);
        fold1    = 12'(prod[13:7]) * 12'(FOLD) + 12'(prod[6:0]);
        fold2    = 10'(fold1[11:7]) * 10'(FOLD) + 10'(fold1[6:0]);
        with_sum = fold2 + 10'(r_sum);
        fold3    = 8'(with_sum[9:7]) * 8'(FOLD) + 8'(with_sum[6:0]);
        if (fold3 >= 8'(2 * c128b_pkg::CHECK_MOD)) begin
            n_sum = 7'(fold3 - 8'(2 * c128b_pkg::CHECK_MOD));
        end else if (fold3 >= 8'(c128b_pkg::CHECK_MOD)) begin
            n_sum = 7'(fold3 - 8'(c128b_pkg::CHECK_MOD));
        end else begin
            n_sum = 7'(fold3);
        end
        n_weight = (r_weight == WEIGHT_WRAP) ? 7'd0 : (r_weight + 7'd1);
        if (n_sum < c128b_pkg::FONT_SPLIT) begin
            n_check_sym = 8'(n_sum) + c128b_pkg::LOW_OFFSET;
        end else begin
            n_check_sym = 8'(n_sum) + c128b_pkg::HIGH_OFFSET;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rec_valid <= 1'b0;
            r_sum       <= c128b_pkg::START_CODE;
            r_weight    <= c128b_pkg::START_WEIGHT;
            r_in_msg    <= 1'b0;
        end else if (acc) begin
            r_rec_valid <= 1'b1;
            if (i_is_last) begin
                r_sum    <= c128b_pkg::START_CODE;
                r_weight <= c128b_pkg::START_WEIGHT;
                r_in_msg <= 1'b0;
            end else begin
                r_sum    <= n_sum;
                r_weight <= n_weight;
                r_in_msg <= 1'b1;
            end
        end else if (i_rec_pop) begin
            r_rec_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_rec.has_start <= !r_in_msg;
            r_rec.char_in   <= i_char_in;
            r_rec.is_last   <= i_is_last;
            r_rec.check_sym <= n_check_sym;
        end
    end

    assign o_rec_valid = r_rec_valid;
    assign o_rec       = r_rec;

    `C128B_ASSERT(a_end_resets_state, i_clk, i_rst_n, (acc && i_is_last) |=> (r_sum == c128b_pkg::START_CODE && r_weight == c128b_pkg::START_WEIGHT && !r_in_msg), "state not cleared after last character")
    `C128B_ASSERT(a_start_on_first, i_clk, i_rst_n, acc |=> (r_rec.has_start == !$past(r_in_msg)), "start flag does not follow message state")
    `C128B_ASSERT(a_weight_steps, i_clk, i_rst_n, (acc && !i_is_last && r_weight != WEIGHT_WRAP) |=> (r_weight == $past(r_weight) + 7'd1), "position weight did not advance")

endmodule

[hw/rtl/c128b_serializer.sv]
// Walks a burst record symbol by symbol into the output register.
// Depends on c128b_pkg and the assertion macro header.
`include "code128b_check_framer_core_macros.svh"

module c128b_serializer (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_rec_valid,
    input  c128b_pkg::t_rec   i_rec,
    output logic              o_rec_pop,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [7:0]        o_symbol,
    output logic              o_last_of_run
);

    typedef enum logic [1:0] {
        PH_START,
        PH_DATA,
        PH_CHECK,
        PH_STOP
    } t_phase;

    t_phase     r_phase;
    logic       r_out_valid;
    logic [7:0] r_symbol;
    logic       r_last_of_run;

    t_phase     eff_phase;
    t_phase     n_phase;
    logic [7:0] cur_sym;
    logic       cur_last;
    logic       cur_final;
    logic       move;

    always_comb begin
        eff_phase = (r_phase == PH_START && !i_rec.has_start) ? PH_DATA : r_phase;
        case (eff_phase)
            PH_START: begin
                cur_sym   = c128b_pkg::START_SYMBOL;
                cur_last  = 1'b0;
                cur_final = 1'b0;
                n_phase   = PH_DATA;
            end
            PH_DATA: begin
                cur_sym   = {1'b0, i_rec.char_in};
                cur_last  = !i_rec.is_last;
                cur_final = !i_rec.is_last;
                n_phase   = i_rec.is_last ? PH_CHECK : PH_START;
            end
            PH_CHECK: begin
                cur_sym   = i_rec.check_sym;
                cur_last  = 1'b0;
                cur_final = 1'b0;
                n_phase   = PH_STOP;
            end
            PH_STOP: begin
                cur_sym   = c128b_pkg::STOP_SYMBOL;
                cur_last  = 1'b1;
                cur_final = 1'b1;
                n_phase   = PH_START;
            end
            default: begin
                cur_sym   = c128b_pkg::START_SYMBOL;
                cur_last  = 1'b0;
                cur_final = 1'b0;
                n_phase   = PH_DATA;
            end
        endcase
    end

    assign move      = i_rec_valid && (!r_out_valid || i_ready);
    assign o_rec_pop = move && cur_final;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_START;
            r_out_valid <= 1'b0;
        end else if (move) begin
            r_phase       <= n_phase;
            r_out_valid   <= 1'b1;
            r_symbol      <= cur_sym;
            r_last_of_run <= cur_last;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_symbol      = r_symbol;
    assign o_last_of_run = r_last_of_run;

    `C128B_ASSERT(a_pop_restarts, i_clk, i_rst_n, o_rec_pop |=> (r_phase == PH_START), "phase not rewound after record done")
    `C128B_ASSERT(a_check_then_stop, i_clk, i_rst_n, (move && eff_phase == PH_CHECK) |=> (r_phase == PH_STOP && o_valid), "stop does not follow check")
    `C128B_NEVER(a_pop_needs_rec, i_clk, i_rst_n, o_rec_pop && !i_rec_valid, "pop without a record")

endmodule

[hw/rtl/code128b_check_framer_core.sv]
// Top level of the Code 128 set B check framer.
// Depends on c128b_pkg, c128b_check_unit and c128b_serializer.
// Use:
//   Input channel (i_valid / o_ready) carries one set B character per
//   transfer, i_is_last marking the final character of a message.
//   Output channel (o_valid / i_ready) carries font symbols: start 209 before
//   the first character, each character unchanged, and after the last one
//   the check symbol and stop 211. o_last_of_run flags the final symbol
//   caused by an input transfer.
// Path: an input is registered in the record stage, then its first symbol
//   is registered in the output register and shows on o_valid.
// Throughput: one symbol per cycle on the output while i_ready is high; the
//   single output port limits input. Mid-message characters give one symbol
//   each; a first character two, a last three, a one-character message four.
// The check accumulation (7x7 multiply and fold modulo 103) completes in the
//   cycle of the input transfer, so it never throttles input.
// Reset (synchronous, active low) empties both stages and returns the check
//   sum to 104 and the position weight to 1.
// When the receiver stalls, the output register holds its symbol; if the
//   record stage is empty it takes one more input, then o_ready drops.

module code128b_check_framer_core (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // input channel
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [6:0] i_char_in,
    input  logic       i_is_last,
    // output channel
    output logic       o_valid,
    input  logic       i_ready,
    output logic [7:0] o_symbol,
    output logic       o_last_of_run
);

    logic            rec_valid;
    c128b_pkg::t_rec rec;
    logic            rec_pop;

    // Stage 1: check accumulation, one record per accepted character
    c128b_check_unit u_check (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_char_in   (i_char_in),
        .i_is_last   (i_is_last),
        .o_rec_valid (rec_valid),
        .o_rec       (rec),
        .i_rec_pop   (rec_pop)
    );

    // Stage 2: one to four symbols per record into the output register
    c128b_serializer u_ser (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_rec_valid   (rec_valid),
        .i_rec         (rec),
        .o_rec_pop     (rec_pop),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_symbol      (o_symbol),
        .o_last_of_run (o_last_of_run)
    );

endmodule
